[rtl/rdg_pkg.sv]
// ============================================================================
// rdg_pkg - shared types and constants of the density grid unit
// Grid geometry, fixed-point constants, command codes, and the control and
// status bundles between the controller and the datapath.
// ============================================================================
package rdg_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int CELLS    = MAX_COLS * MAX_ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int DATA_W   = 16;
    localparam int CRN_W    = 26;   // corner value, fullness ratio can exceed 1.0
    localparam int SPAN_W   = 23;
    localparam int SX_W     = 25;   // position plus half extent
    localparam int CX_W     = 26;   // signed cell index before clamping
    localparam int DVD_W    = 32;
    localparam int DCNT_W   = 6;
    localparam int ACC_W    = 44;

    localparam logic [DATA_W-1:0] ONE_Q15    = 16'd32768;
    localparam logic [DATA_W-1:0] MIN_CAP    = 16'd33;
    localparam logic [DATA_W-1:0] TRAP_LO    = 16'd1639;
    localparam logic [DATA_W-1:0] TRAP_RISE  = 16'd4915;
    localparam logic [DATA_W-1:0] TRAP_FLAT  = 16'd26214;
    localparam logic [DATA_W-1:0] TRAP_OFS   = 16'd16384;
    localparam logic [DCNT_W-1:0] STEPS_QUOT = 6'd32;
    localparam logic [DCNT_W-1:0] STEPS_FRAC = 6'd16;

    typedef enum logic [2:0] {
        OP_ACCUM   = 3'd0,
        OP_FILL    = 3'd1,
        OP_CONSUME = 3'd2,
        OP_TICK    = 3'd3,
        OP_SDENS   = 3'd4,
        OP_SFULL   = 3'd5,
        OP_MOIST   = 3'd6,
        OP_CLEAR   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        CFG_GRID_WIDTH  = 3'd0,
        CFG_GRID_HEIGHT = 3'd1,
        CFG_CELL_SPAN   = 3'd2,
        CFG_HALF_X      = 3'd3,
        CFG_HALF_Z      = 3'd4,
        CFG_REGROWTH    = 3'd5,
        CFG_DECAY       = 3'd6
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_DISP, S_DIV_GO, S_DIV_WAIT, S_RD, S_RDW,
        S_RATIO, S_LERP, S_SW_RD, S_SW_WR, S_MOIST
    } state_t;

    typedef enum logic [2:0] {
        DIV_X, DIV_XF, DIV_Z, DIV_ZF, DIV_RATIO
    } div_sel_t;

    typedef enum logic [1:0] {
        ADR_CORNER, ADR_SWEEP, ADR_MOIST
    } adr_sel_t;

    typedef enum logic [2:0] {
        WD_ZERO, WD_ACC, WD_CONS, WD_TICK, WD_FILL, WD_MOIST
    } wd_sel_t;

    typedef enum logic [1:0] {
        CRN_DENS, CRN_RATIO, CRN_ZERO
    } crn_src_t;

    typedef enum logic [1:0] {
        VAL_ZERO, VAL_CONS, VAL_SAMPLE
    } val_sel_t;

    typedef struct packed {
        logic       load;
        logic       div_go;
        logic       div_take;
        div_sel_t   div_sel;
        logic [1:0] corner;
        logic       crn_take;
        crn_src_t   crn_src;
        adr_sel_t   addr_sel;
        logic       wr_dens;
        logic       wr_cap;
        wd_sel_t    wd_sel;
        logic [1:0] lerp_idx;
        logic       lerp_a;
        logic       lerp_b;
        logic       lerp_put;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       out_set;
        val_sel_t   val_sel;
    } ctl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic div_done;
        logic cap_small;
        logic cnt_last;
        logic moist_ok;
    } ctl_stat_t;

endpackage

[rtl/regrowing_density_grid_unit.sv]
// ============================================================================
// regrowing_density_grid_unit - density and capacity grid with sampling
// Two Q1.15 cell grids with accumulate, fill, consume, tick, bilinear
// density and fullness sampling, moisture-driven capacity and clear.
// ============================================================================
// Usage:
//   Issue a command by raising start with the payload while busy is low;
//   the command is taken at that edge. Exactly one result follows, shown on
//   value and cmd_echo for one cycle with done high; the receiver cannot
//   stall it. The next command may be issued once busy falls.
//   Configuration is written over cfg_valid/cfg_index/cfg_data (cfg_ready
//   is always high); the user must write it only while the unit is idle, which the block itself does not enforce.
//   Latency is set by the shared one-bit-a-cycle divider and the
//   single-port grid RAMs: coordinate commands run four divisions (two
//   cell quotients and two fractions); a fullness sample adds a ratio
//   divide per corner whose capacity is not below MIN_CAP. Fill and tick
//   read and write every cell. Clear writes one cell a cycle.
//   After reset both grids are cleared in a sweep pass with busy high;
//   no result is produced for it.
// ============================================================================
module regrowing_density_grid_unit
    import rdg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [2:0]        cmd,
    input  logic [23:0]       pos_x,
    input  logic [23:0]       pos_z,
    input  logic [15:0]       amount,
    input  logic [15:0]       time_step,
    input  logic [5:0]        cell_col,
    input  logic [5:0]        cell_row,
    input  logic [15:0]       moisture,
    output logic              done,
    output logic [15:0]       value,
    output logic [2:0]        cmd_echo,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [SPAN_W-1:0] cfg_data
);

    ctl_cmd_t  ctl;
    ctl_stat_t stat;

    assign cfg_ready = 1'b1;

    rdg_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctl   (ctl)
    );

    rdg_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .pos_x     (pos_x),
        .pos_z     (pos_z),
        .amount    (amount),
        .time_step (time_step),
        .cell_col  (cell_col),
        .cell_row  (cell_row),
        .moisture  (moisture),
        .done      (done),
        .value     (value),
        .cmd_echo  (cmd_echo)
    );

endmodule

[rtl/rdg_ram.sv]
// ============================================================================
// rdg_ram - single-port RAM
// One address per cycle, optional write, read data registered (old data on a write).
// ============================================================================
module rdg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

[rtl/rdg_ctrl.sv]
// ============================================================================
// rdg_ctrl - command sequencer
// Walks each command through coordinate division, store access, corner
// collection, interpolation and whole-grid sweeps.
// ============================================================================
module rdg_ctrl
    import rdg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  ctl_stat_t stat,
    output ctl_cmd_t  ctl
);

    state_t     state_reg, state_next;
    div_sel_t   dsel_reg, dsel_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] li_reg, li_next;
    logic [1:0] lph_reg, lph_next;
    logic       rsp_reg, rsp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            dsel_reg  <= DIV_X;
            k_reg     <= 2'd0;
            li_reg    <= 2'd0;
            lph_reg   <= 2'd0;
            rsp_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
            k_reg     <= k_next;
            li_reg    <= li_next;
            lph_reg   <= lph_next;
            rsp_reg   <= rsp_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dsel_next  = dsel_reg;
        k_next     = k_reg;
        li_next    = li_reg;
        lph_next   = lph_reg;
        rsp_next   = rsp_reg;
        busy       = (state_reg != S_IDLE);

        ctl.load     = 1'b0;
        ctl.div_go   = 1'b0;
        ctl.div_take = 1'b0;
        ctl.div_sel  = dsel_reg;
        ctl.corner   = k_reg;
        ctl.crn_take = 1'b0;
        ctl.crn_src  = CRN_DENS;
        ctl.addr_sel = ADR_CORNER;
        ctl.wr_dens  = 1'b0;
        ctl.wr_cap   = 1'b0;
        ctl.wd_sel   = WD_ZERO;
        ctl.lerp_idx = li_reg;
        ctl.lerp_a   = 1'b0;
        ctl.lerp_b   = 1'b0;
        ctl.lerp_put = 1'b0;
        ctl.cnt_clr  = 1'b0;
        ctl.cnt_inc  = 1'b0;
        ctl.out_set  = 1'b0;
        ctl.val_sel  = VAL_ZERO;

        unique case (state_reg)
            S_CLR:
            begin
                ctl.addr_sel = ADR_SWEEP;
                ctl.wr_dens  = 1'b1;
                ctl.wr_cap   = 1'b1;
                ctl.wd_sel   = WD_ZERO;
                ctl.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                begin
                    ctl.out_set = rsp_reg;
                    rsp_next    = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.op)
                    OP_ACCUM, OP_CONSUME, OP_SDENS, OP_SFULL:
                    begin
                        dsel_next  = DIV_X;
                        state_next = S_DIV_GO;
                    end
                    OP_FILL, OP_TICK:
                    begin
                        ctl.cnt_clr = 1'b1;
                        state_next  = S_SW_RD;
                    end
                    OP_MOIST:
                    begin
                        state_next = S_MOIST;
                    end
                    OP_CLEAR:
                    begin
                        ctl.cnt_clr = 1'b1;
                        rsp_next    = 1'b1;
                        state_next  = S_CLR;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_DIV_GO:
            begin
                ctl.div_go = 1'b1;
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    ctl.div_take = 1'b1;
                    unique case (dsel_reg)
                        DIV_X:
                        begin
                            dsel_next  = DIV_XF;
                            state_next = S_DIV_GO;
                        end
                        DIV_XF:
                        begin
                            dsel_next  = DIV_Z;
                            state_next = S_DIV_GO;
                        end
                        DIV_Z:
                        begin
                            dsel_next  = DIV_ZF;
                            state_next = S_DIV_GO;
                        end
                        default:
                        begin
                            k_next     = 2'd0;
                            state_next = S_RD;
                        end
                    endcase
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                unique case (stat.op)
                    OP_ACCUM:
                    begin
                        ctl.wr_cap  = 1'b1;
                        ctl.wd_sel  = WD_ACC;
                        ctl.out_set = 1'b1;
                        state_next  = S_IDLE;
                    end
                    OP_CONSUME:
                    begin
                        ctl.wr_dens = 1'b1;
                        ctl.wd_sel  = WD_CONS;
                        ctl.out_set = 1'b1;
                        ctl.val_sel = VAL_CONS;
                        state_next  = S_IDLE;
                    end
                    default:
                    begin
                        if (stat.op == OP_SFULL && !stat.cap_small)
                        begin
                            ctl.div_sel = DIV_RATIO;
                            ctl.div_go  = 1'b1;
                            state_next  = S_RATIO;
                        end
                        else
                        begin
                            ctl.crn_take = 1'b1;
                            ctl.crn_src  = (stat.op == OP_SFULL) ? CRN_ZERO : CRN_DENS;
                            k_next       = k_reg + 2'd1;
                            if (k_reg == 2'd3)
                            begin
                                li_next    = 2'd0;
                                lph_next   = 2'd0;
                                state_next = S_LERP;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                    end
                endcase
            end
            S_RATIO:
            begin
                ctl.div_sel = DIV_RATIO;
                if (stat.div_done)
                begin
                    ctl.div_take = 1'b1;
                    ctl.crn_take = 1'b1;
                    ctl.crn_src  = CRN_RATIO;
                    k_next       = k_reg + 2'd1;
                    if (k_reg == 2'd3)
                    begin
                        li_next    = 2'd0;
                        lph_next   = 2'd0;
                        state_next = S_LERP;
                    end
                    else
                    begin
                        state_next = S_RD;
                    end
                end
            end
            S_LERP:
            begin
                unique case (lph_reg)
                    2'd0:
                    begin
                        ctl.lerp_a = 1'b1;
                        lph_next   = 2'd1;
                    end
                    2'd1:
                    begin
                        ctl.lerp_b = 1'b1;
                        lph_next   = 2'd2;
                    end
                    default:
                    begin
                        ctl.lerp_put = 1'b1;
                        lph_next     = 2'd0;
                        li_next      = li_reg + 2'd1;
                        if (li_reg == 2'd2)
                        begin
                            ctl.out_set = 1'b1;
                            ctl.val_sel = VAL_SAMPLE;
                            state_next  = S_IDLE;
                        end
                    end
                endcase
            end
            S_SW_RD:
            begin
                ctl.addr_sel = ADR_SWEEP;
                state_next   = S_SW_WR;
            end
            S_SW_WR:
            begin
                ctl.addr_sel = ADR_SWEEP;
                ctl.wr_dens  = 1'b1;
                ctl.wd_sel   = (stat.op == OP_TICK) ? WD_TICK : WD_FILL;
                ctl.cnt_inc  = 1'b1;
                if (stat.cnt_last)
                begin
                    ctl.out_set = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_SW_RD;
                end
            end
            S_MOIST:
            begin
                ctl.addr_sel = ADR_MOIST;
                ctl.wr_cap   = stat.moist_ok;
                ctl.wd_sel   = WD_MOIST;
                ctl.out_set  = 1'b1;
                state_next   = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/rdg_datapath.sv]
// ============================================================================
// rdg_datapath - registers, divider, interpolator and grid stores
// Holds configuration, the latched command, a shared restoring divider, the
// corner and interpolation registers and the two grid RAMs.
// ============================================================================
module rdg_datapath
    import rdg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_cmd_t          ctl,
    output ctl_stat_t         stat,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [SPAN_W-1:0] cfg_data,
    input  logic [2:0]        cmd,
    input  logic [23:0]       pos_x,
    input  logic [23:0]       pos_z,
    input  logic [15:0]       amount,
    input  logic [15:0]       time_step,
    input  logic [5:0]        cell_col,
    input  logic [5:0]        cell_row,
    input  logic [15:0]       moisture,
    output logic              done,
    output logic [15:0]       value,
    output logic [2:0]        cmd_echo
);

    // configuration
    logic [6:0]        gw_reg, gh_reg;
    logic [SPAN_W-1:0] span_reg, hx_reg, hz_reg;
    logic [15:0]       rg_reg, dc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg   <= 7'd64;
            gh_reg   <= 7'd64;
            span_reg <= 23'd256;
            hx_reg   <= 23'd8192;
            hz_reg   <= 23'd8192;
            rg_reg   <= 16'd0;
            dc_reg   <= 16'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_WIDTH:  gw_reg   <= cfg_data[6:0];
                CFG_GRID_HEIGHT: gh_reg   <= cfg_data[6:0];
                CFG_CELL_SPAN:   span_reg <= cfg_data;
                CFG_HALF_X:      hx_reg   <= cfg_data;
                CFG_HALF_Z:      hz_reg   <= cfg_data;
                CFG_REGROWTH:    rg_reg   <= cfg_data[15:0];
                CFG_DECAY:       dc_reg   <= cfg_data[15:0];
                default:         ;
            endcase
        end
    end

    logic [6:0]        weff, heff;
    logic [SPAN_W-1:0] span;

    always_comb
    begin
        weff = gw_reg;
        if (gw_reg == 7'd0)
        begin
            weff = 7'd1;
        end
        else if (gw_reg > 7'(MAX_COLS))
        begin
            weff = 7'(MAX_COLS);
        end
        heff = gh_reg;
        if (gh_reg == 7'd0)
        begin
            heff = 7'd1;
        end
        else if (gh_reg > 7'(MAX_ROWS))
        begin
            heff = 7'(MAX_ROWS);
        end
        span = (span_reg == '0) ? SPAN_W'(1) : span_reg;
    end

    // latched command
    op_t         op_reg;
    logic [23:0] px_reg, pz_reg;
    logic [15:0] amt_reg, dt_reg, mst_reg;
    logic [5:0]  col_reg, row_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= op_t'(cmd);
            px_reg  <= pos_x;
            pz_reg  <= pos_z;
            amt_reg <= amount;
            dt_reg  <= time_step;
            col_reg <= cell_col;
            row_reg <= cell_row;
            mst_reg <= moisture;
        end
    end

    // tick steps, settled well before the sweep starts
    logic [23:0] grow_reg, dec_reg;
    logic [31:0] grow_prod, dec_prod;

    assign grow_prod = rg_reg * dt_reg;
    assign dec_prod  = dc_reg * dt_reg;

    always_ff @(posedge clk)
    begin
        grow_reg <= grow_prod[31:8];
        dec_reg  <= dec_prod[31:8];
    end

    // world position shifted by the half extent
    logic signed [SX_W-1:0] sx, sz;
    logic [SX_W-1:0]        ux, uz;

    assign sx = $signed({px_reg[23], px_reg}) + $signed({2'b00, hx_reg});
    assign sz = $signed({pz_reg[23], pz_reg}) + $signed({2'b00, hz_reg});
    // floor division of a negative value via the complement
    assign ux = sx[SX_W-1] ? ~sx : sx;
    assign uz = sz[SX_W-1] ? ~sz : sz;

    // shared restoring divider, one quotient bit a cycle
    logic [SPAN_W-1:0] dv_rem_reg, dv_den_reg;
    logic [DVD_W-1:0]  dv_q_reg;
    logic [DCNT_W-1:0] dv_cnt_reg;
    logic              dv_act_reg;
    logic [SPAN_W:0]   dv_sh, dv_diff;
    logic              dv_bit;

    assign dv_sh   = {dv_rem_reg, dv_q_reg[DVD_W-1]};
    assign dv_diff = dv_sh - {1'b0, dv_den_reg};
    assign dv_bit  = (dv_sh >= {1'b0, dv_den_reg});

    logic signed [CX_W-1:0] cx_reg, cz_reg;
    logic [SPAN_W-1:0]      rx_reg, rz_reg;
    logic [15:0]            tx_reg, tz_reg;
    logic [DATA_W-1:0]      dens_rd, cap_rd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_act_reg <= 1'b0;
            dv_cnt_reg <= '0;
        end
        else if (ctl.div_go)
        begin
            dv_act_reg <= 1'b1;
            dv_cnt_reg <= (ctl.div_sel == DIV_XF || ctl.div_sel == DIV_ZF) ?
                          STEPS_FRAC : STEPS_QUOT;
        end
        else if (ctl.div_take)
        begin
            dv_act_reg <= 1'b0;
        end
        else if (dv_cnt_reg != '0)
        begin
            dv_cnt_reg <= dv_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.div_go)
        begin
            case (ctl.div_sel)
                DIV_X:
                begin
                    dv_den_reg <= span;
                    dv_rem_reg <= '0;
                    dv_q_reg   <= DVD_W'(ux);
                end
                DIV_XF:
                begin
                    dv_den_reg <= span;
                    dv_rem_reg <= rx_reg;
                    dv_q_reg   <= '0;
                end
                DIV_Z:
                begin
                    dv_den_reg <= span;
                    dv_rem_reg <= '0;
                    dv_q_reg   <= DVD_W'(uz);
                end
                DIV_ZF:
                begin
                    dv_den_reg <= span;
                    dv_rem_reg <= rz_reg;
                    dv_q_reg   <= '0;
                end
                default:
                begin
                    dv_den_reg <= SPAN_W'(cap_rd);
                    dv_rem_reg <= '0;
                    dv_q_reg   <= {1'b0, dens_rd, 15'd0};
                end
            endcase
        end
        else if (dv_cnt_reg != '0)
        begin
            dv_rem_reg <= dv_bit ? dv_diff[SPAN_W-1:0] : dv_sh[SPAN_W-1:0];
            dv_q_reg   <= {dv_q_reg[DVD_W-2:0], dv_bit};
        end
    end

    // capture the divider result, restoring floor semantics for negatives
    logic [CX_W-1:0] q_ext;

    assign q_ext = {1'b0, dv_q_reg[SX_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (ctl.div_take)
        begin
            case (ctl.div_sel)
                DIV_X:
                begin
                    cx_reg <= sx[SX_W-1] ? $signed(~q_ext) : $signed(q_ext);
                    rx_reg <= sx[SX_W-1] ? span - SPAN_W'(1) - dv_rem_reg : dv_rem_reg;
                end
                DIV_XF:  tx_reg <= dv_q_reg[15:0];
                DIV_Z:
                begin
                    cz_reg <= sz[SX_W-1] ? $signed(~q_ext) : $signed(q_ext);
                    rz_reg <= sz[SX_W-1] ? span - SPAN_W'(1) - dv_rem_reg : dv_rem_reg;
                end
                DIV_ZF:  tz_reg <= dv_q_reg[15:0];
                default: ;
            endcase
        end
    end

    // clamped corner coordinates
    function automatic logic [COL_W-1:0] clamp_idx(input logic signed [CX_W-1:0] c,
                                                   input logic [6:0] lim);
        logic signed [CX_W-1:0] top;
        top = $signed({{(CX_W-7){1'b0}}, lim}) - CX_W'(1);
        if (c < 0)
        begin
            return '0;
        end
        else if (c > top)
        begin
            return COL_W'(top);
        end
        else
        begin
            return COL_W'(c);
        end
    endfunction

    logic [COL_W-1:0] x0, x1, xs;
    logic [ROW_W-1:0] z0, z1, zs;

    assign x0 = clamp_idx(cx_reg, weff);
    assign x1 = clamp_idx(cx_reg + CX_W'(1), weff);
    assign z0 = ROW_W'(clamp_idx(cz_reg, heff));
    assign z1 = ROW_W'(clamp_idx(cz_reg + CX_W'(1), heff));
    assign xs = ctl.corner[0] ? x1 : x0;
    assign zs = ctl.corner[1] ? z1 : z0;

    // sweep counter
    logic [ADDR_W-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_clr)
        begin
            cnt_reg <= '0;
        end
        else if (ctl.cnt_inc)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // store address
    logic [ADDR_W-1:0] addr;
    logic              moist_ok;

    assign moist_ok = ({1'b0, col_reg} < weff) && ({1'b0, row_reg} < heff);

    always_comb
    begin
        unique case (ctl.addr_sel)
            ADR_SWEEP:  addr = cnt_reg;
            ADR_MOIST:  addr = ADDR_W'(row_reg) * ADDR_W'(weff) + ADDR_W'(col_reg);
            default:    addr = ADDR_W'(zs) * ADDR_W'(weff) + ADDR_W'(xs);
        endcase
    end

    // write data
    logic [16:0]       acc_sum, tick_sum;
    logic [DATA_W-1:0] cons_amt, tick_val, trap_val, dens_wd, cap_wd;
    logic [24:0]       grow_sum;

    assign acc_sum  = {1'b0, cap_rd} + {1'b0, amt_reg};
    assign cons_amt = (dens_rd < amt_reg) ? dens_rd : amt_reg;
    assign grow_sum = {9'd0, dens_rd} + {1'b0, grow_reg};
    assign tick_sum = {1'b0, dens_rd} - {1'b0, cap_rd};

    always_comb
    begin
        tick_val = dens_rd;
        if (dens_rd < cap_rd)
        begin
            tick_val = (grow_sum > {9'd0, cap_rd}) ? cap_rd : grow_sum[15:0];
        end
        else if (dens_rd > cap_rd)
        begin
            tick_val = ({8'd0, tick_sum[15:0]} > dec_reg) ?
                       dens_rd - dec_reg[15:0] : cap_rd;
        end
    end

    always_comb
    begin
        if (mst_reg < TRAP_LO)
        begin
            trap_val = '0;
        end
        else if (mst_reg <= TRAP_RISE)
        begin
            trap_val = 16'(mst_reg * 4'd10) - TRAP_OFS;
        end
        else if (mst_reg <= TRAP_FLAT)
        begin
            trap_val = ONE_Q15;
        end
        else if (mst_reg <= ONE_Q15)
        begin
            trap_val = 16'((ONE_Q15 - mst_reg) * 3'd5);
        end
        else
        begin
            trap_val = '0;
        end
    end

    always_comb
    begin
        dens_wd = '0;
        cap_wd  = '0;
        unique case (ctl.wd_sel)
            WD_ACC:   cap_wd  = (acc_sum > {1'b0, ONE_Q15}) ? ONE_Q15 : acc_sum[15:0];
            WD_CONS:  dens_wd = dens_rd - cons_amt;
            WD_TICK:  dens_wd = tick_val;
            WD_FILL:  dens_wd = cap_rd;
            WD_MOIST: cap_wd  = trap_val;
            default:  ;
        endcase
    end

    rdg_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_dens (
        .clk   (clk),
        .we    (ctl.wr_dens),
        .addr  (addr),
        .wdata (dens_wd),
        .rdata (dens_rd)
    );

    rdg_ram #(.WIDTH(DATA_W), .DEPTH(CELLS)) u_cap (
        .clk   (clk),
        .we    (ctl.wr_cap),
        .addr  (addr),
        .wdata (cap_wd),
        .rdata (cap_rd)
    );

    // corners and interpolation
    logic [CRN_W-1:0] crn_reg [4];
    logic [CRN_W-1:0] top_reg, bot_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.crn_take)
        begin
            case (ctl.crn_src)
                CRN_DENS:  crn_reg[ctl.corner] <= CRN_W'(dens_rd);
                CRN_RATIO: crn_reg[ctl.corner] <= dv_q_reg[CRN_W-1:0];
                default:   crn_reg[ctl.corner] <= '0;
            endcase
        end
    end

    logic [CRN_W-1:0] la, lb;
    logic [15:0]      lt;
    logic [16:0]      lf;
    logic [ACC_W-1:0] lacc_reg, lprod, lround;

    always_comb
    begin
        case (ctl.lerp_idx)
            2'd0:
            begin
                la = crn_reg[0];
                lb = crn_reg[1];
                lt = tx_reg;
            end
            2'd1:
            begin
                la = crn_reg[2];
                lb = crn_reg[3];
                lt = tx_reg;
            end
            default:
            begin
                la = top_reg;
                lb = bot_reg;
                lt = tz_reg;
            end
        endcase
    end

    assign lf     = ctl.lerp_a ? (17'h10000 - {1'b0, lt}) : {1'b0, lt};
    assign lprod  = ACC_W'(ctl.lerp_a ? la : lb) * ACC_W'(lf);
    assign lround = lacc_reg + ACC_W'(32768);

    always_ff @(posedge clk)
    begin
        if (ctl.lerp_a)
        begin
            lacc_reg <= lprod;
        end
        else if (ctl.lerp_b)
        begin
            lacc_reg <= lacc_reg + lprod;
        end
        if (ctl.lerp_put && ctl.lerp_idx == 2'd0)
        begin
            top_reg <= lround[CRN_W+15:16];
        end
        if (ctl.lerp_put && ctl.lerp_idx == 2'd1)
        begin
            bot_reg <= lround[CRN_W+15:16];
        end
    end

    // result
    logic [CRN_W-1:0]  samp;
    logic [DATA_W-1:0] res_val;

    assign samp = lround[CRN_W+15:16];

    always_comb
    begin
        unique case (ctl.val_sel)
            VAL_CONS:   res_val = cons_amt;
            VAL_SAMPLE: res_val = (samp > CRN_W'(ONE_Q15)) ? ONE_Q15 : samp[15:0];
            default:    res_val = '0;
        endcase
    end

    logic done_reg;
    logic [15:0] value_reg;
    logic [2:0]  cmd_echo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.out_set;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_set)
        begin
            value_reg    <= res_val;
            cmd_echo_reg <= op_reg;
        end
    end

    assign done     = done_reg;
    assign value    = value_reg;
    assign cmd_echo = cmd_echo_reg;

    assign stat.op        = op_reg;
    assign stat.div_done  = dv_act_reg && (dv_cnt_reg == '0);
    assign stat.cap_small = (cap_rd < MIN_CAP);
    assign stat.cnt_last  = (cnt_reg == ADDR_W'(CELLS - 1));
    assign stat.moist_ok  = moist_ok;

endmodule

[tb/regrowing_density_grid_unit_tb.sv]
// ============================================================================
// regrowing_density_grid_unit_tb - self-checking bench for the density grid
// Drives grid commands through the start/busy port, predicts every result
// with a cycle-free model of both grids, and compares each done transaction
// in order. Runs a directed set at reset geometry, then random phases under
// several geometry and rate settings written between phases.
// ============================================================================
module regrowing_density_grid_unit_tb;
    import rdg_pkg::*;

    typedef struct packed {
        op_t                op;
        logic signed [23:0] px;
        logic signed [23:0] pz;
        logic [15:0]        amt;
        logic [15:0]        dt;
        logic [5:0]         col;
        logic [5:0]         row;
        logic [15:0]        moist;
    } grid_cmd_t;

    typedef struct packed {
        logic [15:0] val;
        op_t         op;
    } grid_result_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              done;
    logic [15:0]       value;
    logic [2:0]        cmd_echo;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [2:0]        cfg_index;
    logic [SPAN_W-1:0] cfg_data;
    grid_cmd_t         cur;

    grid_cmd_t    pending_cmds[$];
    grid_result_t expected_results[$];
    int           accepted_cnt;
    int           err_cnt;
    logic         take;

    // model state
    logic [15:0] grid_dens [CELLS];
    logic [15:0] grid_cap  [CELLS];
    longint      m_cols, m_rows, m_span, m_hx, m_hz, m_grow, m_decay;

    regrowing_density_grid_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cur.op),
        .pos_x     (cur.px),
        .pos_z     (cur.pz),
        .amount    (cur.amt),
        .time_step (cur.dt),
        .cell_col  (cur.col),
        .cell_row  (cur.row),
        .moisture  (cur.moist),
        .done      (done),
        .value     (value),
        .cmd_echo  (cmd_echo),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic longint eff_cols();
        if (m_cols == 0) return 1;
        if (m_cols > MAX_COLS) return MAX_COLS;
        return m_cols;
    endfunction

    function automatic longint eff_rows();
        if (m_rows == 0) return 1;
        if (m_rows > MAX_ROWS) return MAX_ROWS;
        return m_rows;
    endfunction

    function automatic void locate(input longint pos, input longint half,
                                   output longint cell_idx, output longint frac);
        longint span;
        longint s;
        longint r;
        span = (m_span == 0) ? 1 : m_span;
        s = pos + half;
        cell_idx = s / span;
        r = s % span;
        if (r < 0)
        begin
            cell_idx = cell_idx - 1;
            r = r + span;
        end
        frac = (r * 65536) / span;
    endfunction

    function automatic longint clamp_idx(longint v, longint n);
        if (v < 0) return 0;
        if (v > n - 1) return n - 1;
        return v;
    endfunction

    function automatic longint blend(longint a, longint b, longint t);
        return (a * (65536 - t) + b * t + 32768) >>> 16;
    endfunction

    function automatic longint corner_val(longint idx, bit full);
        longint d;
        longint c;
        d = grid_dens[idx];
        c = grid_cap[idx];
        if (!full) return d;
        if (c < 33) return 0;
        return (d * 32768) / c;
    endfunction

    function automatic longint bilinear(longint px, longint pz, bit full);
        longint w, h, cx, cz, tx, tz, x0, x1, z0, z1, top, bot, v;
        w = eff_cols();
        h = eff_rows();
        locate(px, m_hx, cx, tx);
        locate(pz, m_hz, cz, tz);
        x0 = clamp_idx(cx, w);
        x1 = clamp_idx(cx + 1, w);
        z0 = clamp_idx(cz, h);
        z1 = clamp_idx(cz + 1, h);
        top = blend(corner_val(z0 * w + x0, full), corner_val(z0 * w + x1, full), tx);
        bot = blend(corner_val(z1 * w + x0, full), corner_val(z1 * w + x1, full), tx);
        v = blend(top, bot, tz);
        return (v > 32768) ? 32768 : v;
    endfunction

    function automatic longint trapezoid_cap(longint m);
        if (m < 1639) return 0;
        if (m <= 4915) return 10 * m - 16384;
        if (m <= 26214) return 32768;
        if (m <= 32768) return 5 * (32768 - m);
        return 0;
    endfunction

    function automatic longint cell_of(longint px, longint pz);
        longint cx, cz, tx, tz;
        locate(px, m_hx, cx, tx);
        locate(pz, m_hz, cz, tz);
        return clamp_idx(cz, eff_rows()) * eff_cols() + clamp_idx(cx, eff_cols());
    endfunction

    function automatic grid_result_t apply_grid_cmd(grid_cmd_t c);
        grid_result_t r;
        longint idx, d, cp, grow, dec;
        r.op = c.op;
        r.val = '0;
        case (c.op)
            OP_ACCUM:
            begin
                idx = cell_of(c.px, c.pz);
                cp = grid_cap[idx] + c.amt;
                grid_cap[idx] = (cp > 32768) ? 16'd32768 : cp[15:0];
            end
            OP_FILL:
            begin
                for (int i = 0; i < CELLS; i++) grid_dens[i] = grid_cap[i];
            end
            OP_CONSUME:
            begin
                idx = cell_of(c.px, c.pz);
                d = grid_dens[idx];
                cp = (d < c.amt) ? d : c.amt;
                grid_dens[idx] = 16'(d - cp);
                r.val = cp[15:0];
            end
            OP_TICK:
            begin
                grow = (m_grow * c.dt) >>> 8;
                dec = (m_decay * c.dt) >>> 8;
                for (int i = 0; i < CELLS; i++)
                begin
                    d = grid_dens[i];
                    cp = grid_cap[i];
                    if (d < cp)
                    begin
                        d = d + grow;
                        if (d > cp) d = cp;
                    end
                    else if (d > cp)
                    begin
                        d = (d - cp > dec) ? d - dec : cp;
                    end
                    grid_dens[i] = d[15:0];
                end
            end
            OP_SDENS: r.val = 16'(bilinear(c.px, c.pz, 1'b0));
            OP_SFULL: r.val = 16'(bilinear(c.px, c.pz, 1'b1));
            OP_MOIST:
            begin
                if (c.col < eff_cols() && c.row < eff_rows())
                    grid_cap[c.row * eff_cols() + c.col] = 16'(trapezoid_cap(c.moist));
            end
            default:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    grid_dens[i] = '0;
                    grid_cap[i] = '0;
                end
            end
        endcase
        return r;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // driver: one command transaction per start && !busy edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cur <= '0;
        end
        else
        begin
            take = start && !busy;
            if (take)
            begin
                expected_results.push_back(apply_grid_cmd(cur));
                accepted_cnt++;
            end
            if (!start || take)
            begin
                if (pending_cmds.size() > 0 &&
                    ((accepted_cnt >= 700 && accepted_cnt < 1000) ||
                     $urandom_range(0, 99) >= 15))
                begin
                    start <= 1'b1;
                    cur <= pending_cmds.pop_front();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // monitor: results cannot be held off, check every done cycle
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result value=%0d cmd_echo=%0d", value, cmd_echo);
                err_cnt++;
            end
            else
            begin
                grid_result_t e;
                e = expected_results.pop_front();
                if (value !== e.val)
                begin
                    $error("value: expected %0d actual %0d", e.val, value);
                    err_cnt++;
                end
                if (cmd_echo !== e.op)
                begin
                    $error("cmd_echo: expected %0d actual %0d", e.op, cmd_echo);
                    err_cnt++;
                end
            end
        end
    end

    task automatic write_reg(cfg_idx_t idx, logic [SPAN_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_GRID_WIDTH:  m_cols = data & 7'h7F;
            CFG_GRID_HEIGHT: m_rows = data & 7'h7F;
            CFG_CELL_SPAN:   m_span = data;
            CFG_HALF_X:      m_hx = data;
            CFG_HALF_Z:      m_hz = data;
            CFG_REGROWTH:    m_grow = data & 16'hFFFF;
            default:         m_decay = data & 16'hFFFF;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int span, int hx, int hz, int gr, int dc);
        write_reg(CFG_GRID_WIDTH, SPAN_W'(w));
        write_reg(CFG_GRID_HEIGHT, SPAN_W'(h));
        write_reg(CFG_CELL_SPAN, SPAN_W'(span));
        write_reg(CFG_HALF_X, SPAN_W'(hx));
        write_reg(CFG_HALF_Z, SPAN_W'(hz));
        write_reg(CFG_REGROWTH, SPAN_W'(gr));
        write_reg(CFG_DECAY, SPAN_W'(dc));
        cfg_valid <= 1'b0;
    endtask

    task automatic push_cmd(op_t op, int px, int pz, int amt, int dt, int col, int row,
                            int moist);
        grid_cmd_t c;
        c.op = op;
        c.px = 24'(px);
        c.pz = 24'(pz);
        c.amt = 16'(amt);
        c.dt = 16'(dt);
        c.col = 6'(col);
        c.row = 6'(row);
        c.moist = 16'(moist);
        pending_cmds.push_back(c);
    endtask

    function automatic int rand_pos();
        if ($urandom_range(0, 4) == 0) return $urandom;
        return int'($urandom_range(0, 40000)) - 20000;
    endfunction

    task automatic push_random(int n);
        int sel;
        op_t op;
        int moist;
        for (int i = 0; i < n; i++)
        begin
            sel = $urandom_range(0, 999);
            if (sel < 220) op = OP_ACCUM;
            else if (sel < 400) op = OP_CONSUME;
            else if (sel < 580) op = OP_SDENS;
            else if (sel < 760) op = OP_SFULL;
            else if (sel < 957) op = OP_MOIST;
            else if (sel < 972) op = OP_TICK;
            else if (sel < 997) op = OP_FILL;
            else op = OP_CLEAR;
            moist = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1000, 34000);
            push_cmd(op, rand_pos(), rand_pos(),
                     ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 12000),
                     $urandom_range(0, 65535), $urandom_range(0, 63),
                     $urandom_range(0, 63), moist);
        end
    endtask

    task automatic drain();
        while (pending_cmds.size() != 0 || start || expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_GRID_WIDTH;
        cfg_data = '0;
        accepted_cnt = 0;
        err_cnt = 0;
        m_cols = 64; m_rows = 64; m_span = 256;
        m_hx = 8192; m_hz = 8192; m_grow = 0; m_decay = 0;
        for (int i = 0; i < CELLS; i++)
        begin
            grid_dens[i] = '0;
            grid_cap[i] = '0;
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: trapezoid corners, field extremes, every command
        push_cmd(OP_MOIST, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 1, 0, 1638);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 2, 0, 1639);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 3, 0, 4915);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 4, 0, 4916);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 0, 1, 26214);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 1, 1, 26215);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 63, 63, 32768);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 62, 63, 32769);
        push_cmd(OP_MOIST, 0, 0, 0, 0, 2, 1, 65535);
        push_cmd(OP_ACCUM, 8388607, 8388607, 65535, 0, 0, 0, 0);
        push_cmd(OP_ACCUM, -8388608, -8388608, 20, 0, 0, 0, 0);
        push_cmd(OP_ACCUM, -8192 + 100, -8192 + 300, 32768, 0, 0, 0, 0);
        push_cmd(OP_FILL, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_SDENS, -8192 + 128, -8192 + 128, 0, 0, 0, 0, 0);
        push_cmd(OP_SFULL, -8192 + 200, -8192 + 90, 0, 0, 0, 0, 0);
        push_cmd(OP_SFULL, 8388607, -8388608, 0, 0, 0, 0, 0);
        push_cmd(OP_CONSUME, -8192 + 10, -8192 + 10, 0, 0, 0, 0, 0);
        push_cmd(OP_CONSUME, -8192 + 10, -8192 + 10, 65535, 0, 0, 0, 0);
        push_cmd(OP_TICK, 0, 0, 0, 65535, 0, 0, 0);
        push_cmd(OP_SDENS, 8388607, 8388607, 0, 0, 0, 0, 0);
        push_cmd(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
        push_cmd(OP_SFULL, 0, 0, 0, 0, 0, 0, 0);
        drain();

        set_geometry(16, 8, 64, 512, 512, 300, 500);
        push_random(500);
        drain();
        set_geometry(1, 64, 8388607, 0, 8388607, 65535, 65535);
        push_random(500);
        drain();
        set_geometry(0, 127, 0, 8388607, 0, 0, 0);
        push_random(400);
        drain();
        set_geometry(64, 64, 1000, 30000, 100, 2000, 1);
        push_random(600);
        drain();

        if (err_cnt == 0)
            $display("PASS regrowing_density_grid_unit");
        else
            $display("FAIL regrowing_density_grid_unit");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("FAIL regrowing_density_grid_unit");
        $finish;
    end

endmodule

[files.f]
rtl/rdg_pkg.sv
rtl/rdg_ram.sv
rtl/rdg_ctrl.sv
rtl/rdg_datapath.sv
rtl/regrowing_density_grid_unit.sv
tb/regrowing_density_grid_unit_tb.sv
